>>> rtl/tts_pkg.sv
// package: geometry, codes and word types of the text terminal
`timescale 1ns / 1ps

package tts_pkg;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = ROWS * COLUMNS;
  localparam int unsigned ADDR_W  = $clog2(CELLS);

  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned CELL_W = 16;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_PUT  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_NEWLINE  = 8'd10;
  localparam logic [7:0] CH_BLANK    = 8'h20;
  localparam logic [7:0] RESET_COLOR = 8'h07;
  localparam logic [7:0] TAB_STEP    = 8'd4;

  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_COLOR, CH_BLANK};

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CHAR,
    OP_NEWLINE,
    OP_TAB,
    OP_PUT,
    OP_READ
  } op_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       char_code;
    logic [7:0]       entry_color;
    logic [COL_W-1:0] cell_col;
    logic [ROW_W-1:0] cell_row;
  } in_word_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } out_word_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       char_code;
    logic [7:0]       color;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cmd_t;

endpackage

>>> rtl/tts_front.sv
// front end: accepts input words and classifies them into commands
`timescale 1ns / 1ps

module tts_front
  import tts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  input  logic     back_ready,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic on_screen;
  logic open_r;

  // hold off input until the back end has finished its clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else begin
      open_r <= back_ready;
    end
  end

  assign in_ready = open_r && back_ready && !q_full;
  assign q_push   = in_valid && in_ready;

  assign on_screen = ({1'b0, in_data.cell_col} < (COL_W + 1)'(COLUMNS)) &&
                     ({1'b0, in_data.cell_row} < (ROW_W + 1)'(ROWS));

  always_comb begin
    q_cmd.char_code = in_data.char_code;
    q_cmd.color     = in_data.entry_color;
    q_cmd.col       = in_data.cell_col;
    q_cmd.row       = in_data.cell_row;
    q_cmd.op        = OP_NOP;
    case (in_data.kind)
      KIND_CHAR: begin
        if (in_data.char_code == CH_NEWLINE) begin
          q_cmd.op = OP_NEWLINE;
        end else if (in_data.char_code == CH_TAB) begin
          q_cmd.op = OP_TAB;
        end else begin
          q_cmd.op = OP_CHAR;
        end
      end
      KIND_PUT: begin
        q_cmd.op = on_screen ? OP_PUT : OP_NOP;
      end
      KIND_READ: begin
        q_cmd.op = on_screen ? OP_READ : OP_NOP;
      end
      default: begin
        q_cmd.op = OP_NOP;
      end
    endcase
  end

endmodule

>>> rtl/tts_cmd_queue.sv
// short command queue between front end and back end
`timescale 1ns / 1ps

module tts_cmd_queue
  import tts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic valid,
  input  logic pop,
  output cmd_t head
);

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign valid   = (count_r != '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/tts_back.sv
// back end: screen store, cursor, scroll and result register
`timescale 1ns / 1ps

module tts_back
  import tts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic      q_valid,
  input  cmd_t      q_head,
  output logic      q_pop,
  output logic      ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_EXEC,
    S_SCROLL,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [7:0]        text_color_r;
  cmd_t              cmd_r;
  logic [ROW_W-1:0]  prow_r;
  logic [COL_W-1:0]  pcol_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] scr_addr_r;
  logic [COL_W-1:0]  scr_cnt_r;
  logic [ROW_W-1:0]  top_r;
  logic [ROW_W-1:0]  cur_row_r;
  logic [COL_W-1:0]  cur_col_r;
  logic              out_valid_r;
  out_word_t         out_data_r;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data_r;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  logic [ROW_W-1:0]  sel_row;
  logic [COL_W-1:0]  sel_col;
  logic [ROW_W:0]    row_sum;
  logic [ROW_W-1:0]  prow_nxt;
  logic [COL_W:0]    col_step;
  logic [ROW_W:0]    row_step;
  logic              wrap;
  logic [ROW_W:0]    row_wrapped;
  logic              scroll;
  logic [COL_W-1:0]  cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_nxt;
  logic [ROW_W-1:0]  top_nxt;
  logic              cursor_op;
  logic              out_free;

  assign ready     = (state_r != S_CLEAR);
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // logical row to physical row through the rotating top pointer
  assign sel_row  = (q_head.op == OP_PUT || q_head.op == OP_READ) ? q_head.row : cur_row_r;
  assign sel_col  = (q_head.op == OP_PUT || q_head.op == OP_READ) ? q_head.col : cur_col_r;
  assign row_sum  = {1'b0, sel_row} + {1'b0, top_r};
  assign prow_nxt = (row_sum >= (ROW_W + 1)'(ROWS)) ?
                    ROW_W'(row_sum - (ROW_W + 1)'(ROWS)) : ROW_W'(row_sum);

  // cursor movement
  always_comb begin
    col_step = {1'b0, cur_col_r};
    row_step = {1'b0, cur_row_r};
    case (cmd_r.op)
      OP_CHAR: begin
        col_step = {1'b0, cur_col_r} + 1'b1;
      end
      OP_TAB: begin
        col_step = {1'b0, cur_col_r} + TAB_STEP;
      end
      OP_NEWLINE: begin
        col_step = '0;
        row_step = {1'b0, cur_row_r} + 1'b1;
      end
      default: begin
        col_step = {1'b0, cur_col_r};
      end
    endcase
  end

  assign wrap        = (col_step >= (COL_W + 1)'(COLUMNS));
  assign row_wrapped = wrap ? row_step + 1'b1 : row_step;
  assign cursor_op   = (cmd_r.op == OP_CHAR) || (cmd_r.op == OP_TAB) ||
                       (cmd_r.op == OP_NEWLINE);
  assign scroll      = cursor_op && (row_wrapped >= (ROW_W + 1)'(ROWS));
  assign cur_col_nxt = wrap ? '0 : COL_W'(col_step);
  assign cur_row_nxt = scroll ? ROW_W'(ROWS - 1) : ROW_W'(row_wrapped);
  assign top_nxt     = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = {text_color_r, cmd_r.char_code};
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = RESET_CELL;
      end
      S_EXEC: begin
        mem_we    = (cmd_r.op == OP_CHAR) || (cmd_r.op == OP_PUT);
        mem_waddr = addr_r;
        mem_wdata = (cmd_r.op == OP_PUT) ? {cmd_r.color, cmd_r.char_code}
                                         : {text_color_r, cmd_r.char_code};
      end
      S_SCROLL: begin
        mem_we    = 1'b1;
        mem_waddr = scr_addr_r;
        mem_wdata = {text_color_r, CH_BLANK};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= RESET_COLOR;
    end else if (cfg_we) begin
      text_color_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      top_r       <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == ADDR_W'(CELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd_r   <= q_head;
            prow_r  <= prow_nxt;
            pcol_r  <= sel_col;
            state_r <= S_ADDR;
          end
        end
        S_ADDR: begin
          addr_r  <= ADDR_W'(prow_r) * ADDR_W'(COLUMNS) + ADDR_W'(pcol_r);
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (cursor_op) begin
            cur_col_r <= cur_col_nxt;
            cur_row_r <= cur_row_nxt;
          end
          if (scroll) begin
            // old top row becomes the new bottom row
            scr_addr_r <= ADDR_W'(top_r) * ADDR_W'(COLUMNS);
            scr_cnt_r  <= '0;
            top_r      <= top_nxt;
            state_r    <= S_SCROLL;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_SCROLL: begin
          scr_addr_r <= scr_addr_r + 1'b1;
          scr_cnt_r  <= scr_cnt_r + 1'b1;
          if (scr_cnt_r == COL_W'(COLUMNS - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r           <= 1'b1;
            out_data_r.cell_value <= (cmd_r.op == OP_READ) ? rd_data_r : '0;
            out_data_r.cursor_row <= cur_row_r;
            out_data_r.cursor_col <= cur_col_r;
            state_r               <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/text_terminal_cursor_scroll_top.sv
// top level of the character-cell text terminal
`timescale 1ns / 1ps

// Text terminal with a ROWS x COLUMNS screen store of 16-bit cells (attribute
// byte high, character low) and a cursor. After reset the screen store is
// swept to blanks in light grey on black, one cell a cycle, and in_ready stays
// low until the sweep is done; cfg writes are taken at once.
// Accepted words are classified and queued (two entries), then executed by a
// sequencer that owns the screen memory (one write and one read port): an item
// goes from leaving the queue to its result word being loaded through the
// dequeue, address, memory access (and scroll) and result steps. Scrolling
// rotates a top-row pointer instead of moving rows, then blanks the new bottom
// row in the current text color one cell a cycle.

module text_terminal_cursor_scroll_top
  import tts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_head;
  logic back_ready;

  tts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .back_ready (back_ready),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_push_cmd)
  );

  tts_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .head     (q_head)
  );

  tts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .ready     (back_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> bench/tb_top.sv
// testbench for the text terminal: random and directed words checked against a cell-level screen model
`timescale 1ns / 1ps

module tb_top;
  import tts_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;

  text_terminal_cursor_scroll_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // screen model
  logic [CELL_W-1:0] screen_img [CELLS];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [7:0]        ink;

  in_word_t    host_words_q [$];
  out_word_t   pending_replies [$];
  int unsigned queued_words;
  int unsigned send_idle;
  int unsigned recv_idle;
  bit          hold_back;
  bit          in_fire;
  int unsigned mismatches;
  event        hold_trigger;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL text_terminal_cursor_scroll_top");
    $finish;
  end

  function automatic out_word_t predict_terminal(in_word_t w);
    out_word_t         res;
    logic [CELL_W-1:0] value;
    bit                on_screen;
    int unsigned       spot;
    value = '0;
    on_screen = (int'(w.cell_col) < COLUMNS) && (int'(w.cell_row) < ROWS);
    spot = int'(w.cell_row) * COLUMNS + int'(w.cell_col);
    case (w.kind)
      KIND_CHAR: begin
        if (w.char_code == CH_NEWLINE) begin
          cur_row++;
          cur_col = 0;
        end else if (w.char_code == CH_TAB) begin
          cur_col += 32'(TAB_STEP);
        end else begin
          screen_img[cur_row * COLUMNS + cur_col] = {ink, w.char_code};
          cur_col++;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) screen_img[i] = screen_img[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_img[i] = {ink, CH_BLANK};
          cur_row = ROWS - 1;
        end
      end
      KIND_PUT: begin
        if (on_screen) screen_img[spot] = {w.entry_color, w.char_code};
      end
      KIND_READ: begin
        if (on_screen) value = screen_img[spot];
      end
      default: ;
    endcase
    res.cell_value = value;
    res.cursor_row = ROW_W'(cur_row);
    res.cursor_col = COL_W'(cur_col);
    return res;
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $time, field, got, want);
    mismatches++;
  endtask

  function automatic in_word_t noise_word();
    bit [31:0] r;
    r = $urandom;
    return r[$bits(in_word_t)-1:0];
  endfunction

  function automatic in_word_t cell_word(logic [1:0] kind, logic [7:0] ch, logic [7:0] color,
                                         logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    in_word_t w;
    w.kind = kind;
    w.char_code = ch;
    w.entry_color = color;
    w.cell_col = col;
    w.cell_row = row;
    return w;
  endfunction

  function automatic void push_word(in_word_t w);
    host_words_q.push_back(w);
    queued_words++;
  endfunction

  task automatic queue_random(int unsigned count);
    int unsigned stop_at, pick, len, r;
    in_word_t    w;
    stop_at = queued_words + count;
    while (queued_words < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        // a line of text, sometimes longer than the screen is wide
        len = $urandom_range(1, 100);
        for (int k = 0; k < len && queued_words < stop_at; k++) begin
          w = noise_word();
          w.kind = KIND_CHAR;
          r = $urandom_range(99);
          if (r < 8) w.char_code = CH_TAB;
          else if (r < 14) w.char_code = 8'($urandom);
          else w.char_code = 8'($urandom_range(126, 32));
          push_word(w);
        end
        if ($urandom_range(9) < 7 && queued_words < stop_at) begin
          w = noise_word();
          w.kind = KIND_CHAR;
          w.char_code = CH_NEWLINE;
          push_word(w);
        end
      end else if (pick < 80) begin
        w = noise_word();
        w.kind = (pick < 62) ? KIND_PUT : KIND_READ;
        r = $urandom_range(99);
        if (r < 80) begin
          w.cell_col = COL_W'($urandom_range(COLUMNS - 1));
          w.cell_row = ROW_W'($urandom_range(ROWS - 1));
        end else if (r < 90) begin
          w.cell_col = COL_W'($urandom_range(COLUMNS - 1));
          w.cell_row = ROW_W'(ROWS - 1 - $urandom_range(1));
        end
        push_word(w);
      end else if (pick < 95) begin
        len = $urandom_range(1, 30);
        for (int k = 0; k < len && queued_words < stop_at; k++) begin
          w = noise_word();
          w.kind = KIND_CHAR;
          w.char_code = CH_NEWLINE;
          push_word(w);
        end
      end else begin
        push_word(noise_word());
      end
    end
  endtask

  // checked at the rising edge, where the driver never moves the queue or in_valid
  task automatic wait_drained();
    while (host_words_q.size() != 0 || in_valid || pending_replies.size() != 0)
      @(posedge clk);
  endtask

  task automatic settle();
    repeat (COLUMNS + 16) @(negedge clk);
  endtask

  task automatic write_color(logic [7:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    ink = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_fire)) begin
      if (host_words_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_data <= host_words_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_back) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  initial begin
    forever begin
      @(hold_trigger);
      hold_back = 1'b1;
      repeat (400) @(negedge clk);
      hold_back = 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t want;
    in_fire = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_fire = 1'b1;
        pending_replies.push_back(predict_terminal(in_data));
      end
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          flag_mismatch("unexpected word", 32'(out_data), 32'h0);
        end else begin
          want = pending_replies.pop_front();
          if (out_data.cell_value !== want.cell_value)
            flag_mismatch("cell_value", 32'(out_data.cell_value), 32'(want.cell_value));
          if (out_data.cursor_row !== want.cursor_row)
            flag_mismatch("cursor_row", 32'(out_data.cursor_row), 32'(want.cursor_row));
          if (out_data.cursor_col !== want.cursor_col)
            flag_mismatch("cursor_col", 32'(out_data.cursor_col), 32'(want.cursor_col));
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) screen_img[i] = {RESET_COLOR, CH_BLANK};
    cur_row = 0;
    cur_col = 0;
    ink = RESET_COLOR;
    send_idle = 0;
    recv_idle = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // corners, out of range positions, every kind, reset color
    push_word(cell_word(KIND_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    push_word(cell_word(KIND_READ, 8'hff, 8'hff, 7'd79, 5'd24));
    push_word(cell_word(KIND_READ, 8'h00, 8'h00, 7'd127, 5'd31));
    push_word(cell_word(KIND_READ, 8'h00, 8'h00, 7'd80, 5'd0));
    push_word(cell_word(KIND_READ, 8'h00, 8'h00, 7'd0, 5'd25));
    push_word(cell_word(KIND_PUT, 8'hff, 8'hff, 7'd79, 5'd24));
    push_word(cell_word(KIND_READ, 8'h00, 8'h00, 7'd79, 5'd24));
    push_word(cell_word(KIND_PUT, 8'h00, 8'h00, 7'd0, 5'd0));
    push_word(cell_word(KIND_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    push_word(cell_word(KIND_PUT, 8'h55, 8'haa, 7'd80, 5'd3));
    push_word(cell_word(KIND_PUT, 8'h55, 8'haa, 7'd5, 5'd25));
    push_word(cell_word(KIND_PUT, 8'hff, 8'hff, 7'd127, 5'd31));
    push_word(cell_word(KIND_READ, 8'h00, 8'h00, 7'd5, 5'd3));
    push_word(cell_word(KIND_CHAR, 8'h41, 8'h00, 7'd0, 5'd0));
    push_word(cell_word(KIND_CHAR, 8'h00, 8'hff, 7'd127, 5'd31));
    push_word(cell_word(KIND_CHAR, 8'hff, 8'h00, 7'd0, 5'd0));
    push_word(cell_word(KIND_CHAR, CH_TAB, 8'h00, 7'd0, 5'd0));
    push_word(cell_word(KIND_CHAR, CH_NEWLINE, 8'h00, 7'd0, 5'd0));
    push_word(cell_word(KIND_CHAR, CH_TAB, 8'h00, 7'd0, 5'd0));
    push_word(cell_word(KIND_SPARE, 8'hff, 8'hff, 7'd127, 5'd31));
    push_word(cell_word(KIND_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    push_word(cell_word(KIND_READ, 8'h00, 8'h00, 7'd2, 5'd0));
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      settle();
      case (phase)
        0: begin
          send_idle = 12;
          recv_idle = 60;
          write_color(8'hff);
        end
        1: begin
          send_idle = 60;
          recv_idle = 12;
          write_color(8'h00);
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          write_color(8'($urandom_range(254, 1)));
        end
      endcase
      queue_random(380);
      if (phase == 2) -> hold_trigger;
      wait_drained();
    end

    settle();
    if (mismatches == 0) begin
      $display("PASS text_terminal_cursor_scroll_top");
    end else begin
      $display("FAIL text_terminal_cursor_scroll_top");
    end
    $finish;
  end

endmodule
